FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Consequent holds on the same edge as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds on the edge after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg
// Shared constants and types of the serial command carrier modulator.
// ----------------------------------------------------------------------------
package scm_pkg;

    localparam int LINE_DEPTH = 128;
    localparam int IDX_W      = $clog2(LINE_DEPTH);
    localparam int HEAD_LEN   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int BYTE_W     = 8;

    typedef logic [IDX_W-1:0] idx_t;

    localparam logic [IDX_W:0] DEPTH_EXT = (IDX_W+1)'(LINE_DEPTH);

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;

    localparam logic [7:0] CMD_SET_BIT = 8'h6C;  // 'l'
    localparam logic [7:0] CMD_CLR_BIT = 8'h4C;  // 'L'
    localparam logic [7:0] CMD_TICKS   = 8'h74;  // 't'
    localparam logic [7:0] CMD_CARRIER = 8'h66;  // 'f'
    localparam logic [7:0] CMD_PLAY    = 8'h6F;  // 'o'

    localparam logic [7:0] PLAY_START  = 8'd2;
    localparam logic [7:0] PORT_RESET  = 8'h3F;
    localparam int         CARRIER_BIT = 4;

    // play_pos >= length - '0' + 2  <=>  play_pos + ('0' - 2) >= length
    localparam logic [8:0] END_OFFSET = 9'(CH_ZERO) - 9'(PLAY_START);

    typedef struct packed {
        logic             operation;
        logic [BYTE_W-1:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic             echo_valid;
        logic [BYTE_W-1:0] echo_byte;
        logic [BYTE_W-1:0] port_value;
        logic             command_error;
        logic             playing;
    } result_t;

    typedef struct packed {
        logic s1_busy;
        logic hazard;
    } core_status_t;

endpackage

FILE: rtl/scm_item_if.sv
// ----------------------------------------------------------------------------
// scm_item_if
// Request channel: received serial byte or timer tick.
// ----------------------------------------------------------------------------
interface scm_item_if;
    import scm_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

FILE: rtl/scm_result_if.sv
// ----------------------------------------------------------------------------
// scm_result_if
// Result channel: echo, port pins and status after each request.
// ----------------------------------------------------------------------------
interface scm_result_if;
    import scm_pkg::*;

    logic              valid;
    logic              ready;
    logic              echo_valid;
    logic [BYTE_W-1:0] echo_byte;
    logic [BYTE_W-1:0] port_value;
    logic              command_error;
    logic              playing;

    modport source (output valid, output echo_valid, output echo_byte, output port_value,
                    output command_error, output playing, input ready);
    modport sink   (input valid, input echo_valid, input echo_byte, input port_value,
                    input command_error, input playing, output ready);
endinterface

FILE: rtl/scm_core.sv
// ----------------------------------------------------------------------------
// scm_core
// Line store memory and the read/modify/write stage that holds all state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scm_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 issue,
    input  scm_pkg::item_t       issue_item,
    output logic                 res_valid,
    output scm_pkg::result_t     res,
    output scm_pkg::core_status_t status
);
    import scm_pkg::*;

    logic [7:0] line_mem [LINE_DEPTH];
    logic [7:0] q_a_reg, q_b_reg;

    logic       s1_valid_reg;
    item_t      s1_item_reg;
    logic       fwd_a_reg, fwd_b_reg;
    logic [7:0] fwd_data_reg;

    idx_t       write_pos_reg, write_pos_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] play_pos_reg, play_pos_next;
    idx_t       play_idx_reg, play_idx_next;
    logic       carrier_reg, carrier_next;
    logic       active_reg, active_next;
    logic       half_reg, half_next;
    logic       running_reg, running_next;
    logic [7:0] port_reg, port_next;
    logic [7:0] head_reg [HEAD_LEN];
    logic [7:0] head_next [HEAD_LEN];

    logic [IDX_W:0] idx_inc, idx_step, idx_wrap;
    idx_t           rd_b;
    logic           wr_en;
    idx_t           wr_addr;
    logic [7:0]     wr_data;
    logic [7:0]     here, nxt, cmd, bit_n;
    logic           line_end, err;

    // Second read port: entry after the current pattern position, modulo depth
    assign idx_inc = {1'b0, play_idx_reg} + (IDX_W+1)'(1);
    assign rd_b    = (idx_inc == DEPTH_EXT) ? '0 : idx_inc[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            q_a_reg <= line_mem[play_idx_reg];
            q_b_reg <= line_mem[rd_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            write_pos_reg <= '0;
            length_reg    <= '0;
            play_pos_reg  <= PLAY_START;
            play_idx_reg  <= IDX_W'(PLAY_START);
            carrier_reg   <= 1'b0;
            active_reg    <= 1'b0;
            half_reg      <= 1'b0;
            running_reg   <= 1'b1;
            port_reg      <= PORT_RESET;
        end
        else
        begin
            s1_valid_reg  <= issue;
            write_pos_reg <= write_pos_next;
            length_reg    <= length_next;
            play_pos_reg  <= play_pos_next;
            play_idx_reg  <= play_idx_next;
            carrier_reg   <= carrier_next;
            active_reg    <= active_next;
            half_reg      <= half_next;
            running_reg   <= running_next;
            port_reg      <= port_next;
        end
    end

    // Payload: request in flight, write forwarding and the head copy of the line
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_item_reg  <= issue_item;
            fwd_a_reg    <= wr_en && (wr_addr == play_idx_reg);
            fwd_b_reg    <= wr_en && (wr_addr == rd_b);
            fwd_data_reg <= wr_data;
        end
        for (int k = 0; k < HEAD_LEN; k++)
        begin
            head_reg[k] <= head_next[k];
        end
    end

    assign here     = fwd_a_reg ? fwd_data_reg : q_a_reg;
    assign nxt      = fwd_b_reg ? fwd_data_reg : q_b_reg;
    assign line_end = (s1_item_reg.rx_byte == CH_LF) || (s1_item_reg.rx_byte == CH_CR);

    always_comb
    begin
        write_pos_next = write_pos_reg;
        length_next    = length_reg;
        play_pos_next  = play_pos_reg;
        play_idx_next  = play_idx_reg;
        carrier_next   = carrier_reg;
        active_next    = active_reg;
        half_next      = half_reg;
        running_next   = running_reg;
        port_next      = port_reg;
        head_next      = head_reg;
        wr_en          = 1'b0;
        wr_addr        = write_pos_reg;
        wr_data        = s1_item_reg.rx_byte;
        cmd            = head_reg[0];
        bit_n          = '0;
        err            = 1'b0;
        idx_step       = {1'b0, play_idx_reg} + (IDX_W+1)'(2);
        idx_wrap       = idx_step - DEPTH_EXT;

        if (s1_valid_reg)
        begin
            if (s1_item_reg.operation == OP_BYTE)
            begin
                wr_en   = 1'b1;
                wr_addr = write_pos_reg;
                wr_data = s1_item_reg.rx_byte;
                for (int k = 0; k < HEAD_LEN; k++)
                begin
                    if (write_pos_reg == IDX_W'(k))
                    begin
                        head_next[k] = s1_item_reg.rx_byte;
                    end
                end
                if (line_end)
                begin
                    write_pos_next = '0;
                    cmd            = head_next[0];
                    length_next    = head_next[1];
                    bit_n          = head_next[2] - CH_ZERO;
                    unique case (cmd)
                        CMD_SET_BIT:
                        begin
                            if (bit_n < 8'd8)
                            begin
                                port_next[bit_n[2:0]] = 1'b1;
                            end
                        end
                        CMD_CLR_BIT:
                        begin
                            if (bit_n < 8'd8)
                            begin
                                port_next[bit_n[2:0]] = 1'b0;
                            end
                        end
                        CMD_TICKS:   running_next = (bit_n != 8'd0);
                        CMD_CARRIER: carrier_next = (bit_n != 8'd0);
                        CMD_PLAY:
                        begin
                            play_pos_next = PLAY_START;
                            play_idx_next = IDX_W'(PLAY_START);
                            active_next   = 1'b1;
                        end
                        default:     err = 1'b1;
                    endcase
                end
                else if (write_pos_reg != IDX_W'(LINE_DEPTH - 1))
                begin
                    write_pos_next = write_pos_reg + IDX_W'(1);
                end
            end
            else if (running_reg)
            begin
                if (active_reg)
                begin
                    carrier_next = (nxt != CH_ZERO);
                    if (here == CH_ZERO)
                    begin
                        if (half_reg)
                        begin
                            play_pos_next = play_pos_reg + 8'd2;
                            // 8-bit wrap of the position restarts the index too
                            if (play_pos_reg >= 8'd254)
                            begin
                                play_idx_next = IDX_W'(play_pos_next);
                            end
                            else if (idx_step >= DEPTH_EXT)
                            begin
                                play_idx_next = idx_wrap[IDX_W-1:0];
                            end
                            else
                            begin
                                play_idx_next = idx_step[IDX_W-1:0];
                            end
                        end
                        if (({1'b0, play_pos_next} + END_OFFSET) >= {1'b0, length_reg})
                        begin
                            play_pos_next = PLAY_START;
                            play_idx_next = IDX_W'(PLAY_START);
                            active_next   = 1'b0;
                            carrier_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = play_idx_reg;
                        wr_data = here - 8'd1;
                        for (int k = 0; k < HEAD_LEN; k++)
                        begin
                            if (play_idx_reg == IDX_W'(k))
                            begin
                                head_next[k] = here - 8'd1;
                            end
                        end
                    end
                end
                half_next = ~half_reg;
                port_next[CARRIER_BIT] = carrier_next ? ~port_reg[CARRIER_BIT] : 1'b0;
            end
        end
    end

    assign res_valid         = s1_valid_reg;
    assign res.echo_valid    = (s1_item_reg.operation == OP_BYTE);
    assign res.echo_byte     = (s1_item_reg.operation == OP_BYTE) ? s1_item_reg.rx_byte : '0;
    assign res.port_value    = port_next;
    assign res.command_error = err;
    assign res.playing       = active_next;

    // Ticks and line ends change what the next read address depends on
    assign status.s1_busy = s1_valid_reg;
    assign status.hazard  = s1_valid_reg && ((s1_item_reg.operation == OP_TICK) || line_end);

    `ASSERT_NEXT(a_hazard_interlock, status.hazard, !s1_valid_reg,
                 "request entered the stage behind a tick or line end")
    `ASSERT_IMPLY(a_idle_home, !active_reg,
                  (play_pos_reg == PLAY_START) && (play_idx_reg == IDX_W'(PLAY_START)),
                  "playback position not home while idle")

endmodule

FILE: rtl/scm_outq.sv
// ----------------------------------------------------------------------------
// scm_outq
// Two-entry result queue decoupling the core from a stalling receiver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scm_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  scm_pkg::result_t push_data,
    input  logic             pop,
    output logic             valid,
    output scm_pkg::result_t data,
    output logic [1:0]       count
);
    import scm_pkg::*;

    result_t    slot_reg [QUEUE_DEPTH];
    result_t    slot_next [QUEUE_DEPTH];
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
        if (pop)
        begin
            slot_next[0] = slot_reg[1];
            if (push)
            begin
                slot_next[~cnt_reg[0]] = push_data;
            end
        end
        else if (push)
        begin
            slot_next[cnt_reg[0]] = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign valid = (cnt_reg != 2'd0);
    assign data  = slot_reg[0];
    assign count = cnt_reg;

    `ASSERT_IMPLY(a_no_overflow, push && !pop, cnt_reg != 2'(QUEUE_DEPTH),
                  "result pushed into a full queue")
    `ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= 2'(QUEUE_DEPTH), "queue count beyond depth")

endmodule

FILE: rtl/serial_command_carrier_modulator.sv
// ----------------------------------------------------------------------------
// serial_command_carrier_modulator
// Line-buffered serial command decoder driving a toggled carrier on port bit 4.
// ----------------------------------------------------------------------------
// Usage:
//   item   : request channel; operation 0 carries a received byte in rx_byte,
//            operation 1 is a periodic timer tick.
//   result : one result per request: echo, port pins, command error flag
//            and playback status, in request order.
// Results: each result passes the request stage register and then the result
//   queue before it is offered to the receiver.
// Throughput: a received byte that does not end a line may be followed by
//   another request in the next cycle if the result queue has room; a tick or
//   a CR/LF holds off the next request while it is in the stage, since the
//   line store read address (pattern position) is only known after write-back.
// Each request reads the line store as it is taken and writes it back in the
//   cycle after (one write port, two read ports, write forwarding).
// Reset: port pins 0x3F, ticks running, playback idle, line store contents
//   undefined; no clearing pass, requests are taken straight away.
// Stall: a two-entry result queue holds finished results; item.ready drops
//   when the queue and the stage in flight would overfill it, or behind a tick or CR/LF.
// ----------------------------------------------------------------------------
module serial_command_carrier_modulator (
    input  logic         clk,
    input  logic         rst_n,
    scm_item_if.sink     item,
    scm_result_if.source result
);
    import scm_pkg::*;

    core_status_t st;
    item_t        issue_item;
    result_t      core_res, q_data;
    logic         core_valid;
    logic         take, accept;
    logic [1:0]   q_cnt;
    logic [2:0]   pending;

    assign take    = result.valid && result.ready;
    assign pending = {1'b0, q_cnt} + {2'b0, st.s1_busy} - {2'b0, take};

    assign item.ready = !st.hazard && (pending <= 3'd1);
    assign accept     = item.valid && item.ready;

    assign issue_item.operation = item.operation;
    assign issue_item.rx_byte   = item.rx_byte;

    scm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (accept),
        .issue_item (issue_item),
        .res_valid  (core_valid),
        .res        (core_res),
        .status     (st)
    );

    scm_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (core_valid),
        .push_data (core_res),
        .pop       (take),
        .valid     (result.valid),
        .data      (q_data),
        .count     (q_cnt)
    );

    assign result.echo_valid    = q_data.echo_valid;
    assign result.echo_byte     = q_data.echo_byte;
    assign result.port_value    = q_data.port_value;
    assign result.command_error = q_data.command_error;
    assign result.playing       = q_data.playing;

endmodule

FILE: tb/scm_checker.sv
// ----------------------------------------------------------------------------
// scm_checker
// Watches the request and result channels of the carrier modulator, predicts
// each result from its own copy of the line store and playback state, and
// compares the results in order, field by field.
// ----------------------------------------------------------------------------
module scm_checker (
    input  logic  clk,
    input  logic  rst_n,
    scm_item_if   item,
    scm_result_if result,
    output int    fail_count,
    output int    outstanding,
    output int    compared,
    output int    plays_ended
);
    import scm_pkg::*;

    logic [7:0] line_mem [LINE_DEPTH];
    int         wr_idx;
    logic [7:0] head_cmd;
    logic [7:0] head_len;
    logic [7:0] head_arg;
    logic [7:0] pat_pos;
    logic       carrier_on;
    logic       pattern_on;
    logic       half_phase;
    logic       ticks_on;
    logic [7:0] port_pins;
    result_t    expected_q[$];

    // Advances the prediction by one request and returns the result it owes.
    function automatic result_t step_model(input logic op, input logic [7:0] b);
        result_t    r;
        logic [7:0] bit_no;
        int         here;
        int         nxt;
        int         limit;
        r = '0;
        if (op == OP_BYTE)
        begin
            r.echo_valid = 1'b1;
            r.echo_byte  = b;
            line_mem[wr_idx] = b;
            if (b == CH_LF || b == CH_CR)
            begin
                wr_idx   = 0;
                head_cmd = line_mem[0];
                head_len = line_mem[1];
                head_arg = line_mem[2];
                bit_no   = head_arg - CH_ZERO;
                case (head_cmd)
                    CMD_SET_BIT: if (bit_no < 8'd8) port_pins[bit_no[2:0]] = 1'b1;
                    CMD_CLR_BIT: if (bit_no < 8'd8) port_pins[bit_no[2:0]] = 1'b0;
                    CMD_TICKS:   ticks_on   = (bit_no != 8'd0);
                    CMD_CARRIER: carrier_on = (bit_no != 8'd0);
                    CMD_PLAY:
                    begin
                        pat_pos    = PLAY_START;
                        pattern_on = 1'b1;
                    end
                    default:     r.command_error = 1'b1;
                endcase
            end
            else if (wr_idx + 1 < LINE_DEPTH)
            begin
                wr_idx++;
            end
        end
        else if (ticks_on)
        begin
            if (pattern_on)
            begin
                here = int'(pat_pos) % LINE_DEPTH;
                nxt  = (int'(pat_pos) + 1) % LINE_DEPTH;
                carrier_on = (line_mem[nxt] != CH_ZERO);
                if (line_mem[here] == CH_ZERO)
                begin
                    if (half_phase) pat_pos = pat_pos + 8'd2;
                    // signed compare: a length byte below '0' ends at once
                    limit = int'(head_len) - int'(CH_ZERO) + int'(PLAY_START);
                    if (int'(pat_pos) >= limit)
                    begin
                        pat_pos    = PLAY_START;
                        pattern_on = 1'b0;
                        carrier_on = 1'b0;
                        plays_ended++;
                    end
                end
                else
                begin
                    line_mem[here] = line_mem[here] - 8'd1;
                end
            end
            half_phase = ~half_phase;
            if (carrier_on) port_pins[CARRIER_BIT] = ~port_pins[CARRIER_BIT];
            else            port_pins[CARRIER_BIT] = 1'b0;
        end
        r.port_value = port_pins;
        r.playing    = pattern_on;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t seen;
        result_t want;
        if (!rst_n)
        begin
            wr_idx      = 0;
            head_cmd    = '0;
            head_len    = '0;
            head_arg    = '0;
            pat_pos     = PLAY_START;
            carrier_on  = 1'b0;
            pattern_on  = 1'b0;
            half_phase  = 1'b0;
            ticks_on    = 1'b1;
            port_pins   = PORT_RESET;
            expected_q.delete();
            fail_count  = 0;
            outstanding = 0;
            compared    = 0;
            plays_ended = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                seen.echo_valid    = result.echo_valid;
                seen.echo_byte     = result.echo_byte;
                seen.port_value    = result.port_value;
                seen.command_error = result.command_error;
                seen.playing       = result.playing;
                if (expected_q.size() == 0)
                begin
                    $error("result accepted with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("echo_valid", 8'(want.echo_valid), 8'(seen.echo_valid));
                    check_field("echo_byte", want.echo_byte, seen.echo_byte);
                    check_field("port_value", want.port_value, seen.port_value);
                    check_field("command_error", 8'(want.command_error),
                                8'(seen.command_error));
                    check_field("playing", 8'(want.playing), 8'(seen.playing));
                    compared++;
                end
            end
            if (item.valid && item.ready)
                expected_q.push_back(step_model(item.operation, item.rx_byte));
            outstanding = expected_q.size();
        end
    end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives serial bytes and timer ticks into the carrier modulator: a short
// directed part (full line store, every command, out-of-range bits, stopped
// ticks, playback) and then random command lines, patterns and noise, with
// bursty requests and a stalling receiver. Checking is done by scm_checker.
// ----------------------------------------------------------------------------
module testbench;
    import scm_pkg::*;

    localparam int RANDOM_ITEMS = 780;
    localparam int IDLE_LIMIT   = 400;
    localparam int SETTLE       = 8;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   outstanding;
    int   compared;
    int   plays_ended;
    int   requests_sent = 0;
    int   lines_ended   = 0;
    int   ticks_sent    = 0;
    int   burst_left    = 0;
    int   idle_cycles   = 0;

    scm_item_if   item_ch ();
    scm_result_if result_ch ();

    serial_command_carrier_modulator uut (
        .clk,
        .rst_n,
        .item   (item_ch),
        .result (result_ch)
    );

    scm_checker result_check (
        .clk,
        .rst_n,
        .item        (item_ch),
        .result      (result_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .compared    (compared),
        .plays_ended (plays_ended)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] digit(input int d);
        return CH_ZERO + 8'(d);
    endfunction

    function automatic logic [7:0] line_end();
        return ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF;
    endfunction

    // One request; opens a new burst, after an optional gap, when the last one ran out
    task automatic send_request(input logic op, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_ch.valid     <= 1'b1;
        item_ch.operation <= op;
        item_ch.rx_byte   <= b;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        requests_sent++;
        if (op == OP_TICK) ticks_sent++;
        else if (b == CH_CR || b == CH_LF) lines_ended++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_request(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic command_line(input logic [7:0] cmd, input logic [7:0] len,
                                input logic [7:0] arg);
        send_request(OP_BYTE, cmd);
        send_request(OP_BYTE, len);
        send_request(OP_BYTE, arg);
        send_request(OP_BYTE, line_end());
    endtask

    // Pattern line: (count, on) digit pairs from entry 2 onwards
    task automatic play_line(input int pairs, input logic [7:0] len);
        logic [7:0] on_byte;
        send_request(OP_BYTE, CMD_PLAY);
        send_request(OP_BYTE, len);
        repeat (pairs)
        begin
            send_request(OP_BYTE, digit($urandom_range(0, 3)));
            case ($urandom_range(0, 3))
                0, 1:    on_byte = digit(0);
                2:       on_byte = digit(1);
                default: on_byte = 8'($urandom_range(0, 255));
            endcase
            send_request(OP_BYTE, on_byte);
        end
        send_request(OP_BYTE, line_end());
    endtask

    // Receiver: ready follows a repeating 8-bit mask that changes every window
    initial
    begin
        int         window;
        logic [7:0] ready_mask;
        logic [2:0] step;
        window     = 0;
        step       = '0;
        ready_mask = 8'hFF;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (window == 0)
            begin
                window     = $urandom_range(16, 160);
                ready_mask = ($urandom_range(0, 2) == 0) ? 8'hFF
                                                         : 8'($urandom_range(1, 255));
            end
            window--;
            result_ch.ready <= ready_mask[step];
            step++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, outstanding);
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int         start_count;
        int         pairs;
        int         n;
        logic [7:0] b;
        logic [7:0] arg;
        item_ch.valid     <= 1'b0;
        item_ch.operation <= OP_BYTE;
        item_ch.rx_byte   <= '0;
        rst_n             <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // ticks with nothing playing
        send_ticks(2);
        // overlong line: fills every entry, write index saturates on the last
        send_request(OP_BYTE, CMD_CLR_BIT);
        send_request(OP_BYTE, digit(9));
        send_request(OP_BYTE, digit(5));
        repeat (LINE_DEPTH + 2) send_request(OP_BYTE, digit($urandom_range(0, 3)));
        send_request(OP_BYTE, CH_LF);

        command_line(CMD_SET_BIT, digit(0), digit(7));
        command_line(CMD_CLR_BIT, 8'hFF, digit(0));
        command_line(CMD_SET_BIT, 8'h00, digit(8));        // bit out of range
        command_line(CMD_CLR_BIT, digit(1), CH_ZERO - 8'd1); // wraps to 255
        command_line(CMD_SET_BIT, digit(2), digit(CARRIER_BIT));
        command_line(CMD_CARRIER, digit(0), digit(1));
        send_ticks(3);
        command_line(CMD_CARRIER, digit(0), digit(0));
        send_ticks(1);
        command_line(CMD_TICKS, digit(0), digit(0));
        send_ticks(2);                                      // stopped
        command_line(CMD_TICKS, digit(0), digit(1));
        command_line(8'hFF, digit(0), digit(0));            // unknown command
        send_request(OP_BYTE, CH_CR);                       // short line, old entries
        play_line(2, digit(4));
        send_ticks(24);
        play_line(1, 8'h00);                                // length below '0'
        send_ticks(4);

        start_count = requests_sent;
        while (requests_sent - start_count < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8:
                begin
                    pairs = $urandom_range(1, 5);
                    play_line(pairs, ($urandom_range(0, 7) == 0) ?
                                     8'($urandom_range(0, 255)) : digit(2 * pairs));
                    // now and then a new line lands in the middle of playback
                    if ($urandom_range(0, 5) == 0) send_ticks($urandom_range(0, 6));
                    else send_ticks(pairs * 10 + $urandom_range(0, 10));
                end
                9, 10, 11, 12:
                begin
                    arg = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                      : digit($urandom_range(0, 7));
                    command_line(($urandom_range(0, 1) != 0) ? CMD_SET_BIT : CMD_CLR_BIT,
                                 8'($urandom_range(0, 255)), arg);
                    send_ticks($urandom_range(0, 3));
                end
                13:
                begin
                    arg = ($urandom_range(0, 2) == 0) ? digit(0) : 8'($urandom_range(0, 255));
                    command_line(CMD_TICKS, 8'($urandom_range(0, 255)), arg);
                    send_ticks($urandom_range(1, 4));
                    if (arg == CH_ZERO) command_line(CMD_TICKS, digit(0), digit(1));
                end
                14, 15:
                begin
                    arg = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                      : digit($urandom_range(0, 1));
                    command_line(CMD_CARRIER, 8'($urandom_range(0, 255)), arg);
                    send_ticks($urandom_range(2, 8));
                end
                16, 17:
                begin
                    repeat ($urandom_range(1, 12))
                        send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                end
                18:
                begin
                    command_line(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)));
                end
                default:
                begin
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(LINE_DEPTH, LINE_DEPTH + 12)
                                                    : $urandom_range(4, 20);
                    repeat (n)
                    begin
                        do b = 8'($urandom_range(0, 255));
                        while (b == CH_CR || b == CH_LF);
                        send_request(OP_BYTE, b);
                    end
                    send_request(OP_BYTE, line_end());
                end
            endcase
        end

        item_ch.valid <= 1'b0;
        // wait for the checker to log the last request
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Ran %0d requests: %0d lines ended, %0d ticks, %0d pattern runs to the end.",
                 requests_sent, lines_ended, ticks_sent, plays_ended);
        $display("Compared %0d results, %0d field errors.", compared, fail_count);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: serial_command_carrier_modulator.f
+incdir+rtl
rtl/scm_pkg.sv
rtl/scm_item_if.sv
rtl/scm_result_if.sv
rtl/scm_core.sv
rtl/scm_outq.sv
rtl/serial_command_carrier_modulator.sv
tb/scm_checker.sv
tb/testbench.sv
